// ===== src/tsk_pkg.sv =====
`timescale 1ns / 1ps

package tsk_pkg;

  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_DEL  = 2'd1;
  localparam logic [1:0] MODE_SORT = 2'd2;

  localparam int unsigned CNT_W = 6;

  typedef enum logic [1:0] {
    DEG_PASS,
    DEG_INC,
    DEG_DEC
  } deg_op_e;

  typedef struct packed {
    logic in_zero;
    logic out_zero;
  } deg_flags_t;

endpackage

// ===== src/tsk_ram.sv =====
`timescale 1ns / 1ps

module tsk_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tsk_deg_unit.sv =====
`timescale 1ns / 1ps

// Shared in-degree arithmetic: increment, saturating decrement or pass.
module tsk_deg_unit #(
  parameter int unsigned Width = 6
) (
  input  tsk_pkg::deg_op_e    op_i,
  input  logic [Width-1:0]    val_i,
  output logic [Width-1:0]    val_o,
  output tsk_pkg::deg_flags_t flags_o
);

  logic in_zero;

  assign in_zero = (val_i == '0);

  always_comb begin
    case (op_i)
      tsk_pkg::DEG_INC:  val_o = val_i + Width'(1);
      tsk_pkg::DEG_DEC:  val_o = in_zero ? val_i : val_i - Width'(1);
      tsk_pkg::DEG_PASS: val_o = val_i;
      default:           val_o = val_i;
    endcase
  end

  assign flags_o.in_zero  = in_zero;
  assign flags_o.out_zero = (val_o == '0);

endmodule

// ===== src/topological_sort_kahn.sv =====
`timescale 1ns / 1ps
// Edge add/delete: read row and in-degree, then write back. Not ready while busy.
// Sort, n active nodes: accept, read and write per node to seed; per popped node a pop,
// queue read, emit, row read, a scan over the n nodes and a step per successor edge;
// then an empty pop and a final step (just that when n is 0); stalls hold emit and final.
// Reset: empty graph, node_count 32; per-row valid bits stand in for clearing,
// so no clearing pass is run.
module topological_sort_kahn #(
  parameter int unsigned MAX_NODES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,    // node_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // mode[1:0], src_node[6:2], dst_node[11:7]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // node_id[4:0]
  output logic [1:0]  m_axis_tuser,   // node_valid[0], all_sorted[1]
  output logic        m_axis_tlast
);

  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned NCW = $clog2(MAX_NODES + 1);
  localparam int unsigned DW  = NCW;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_EDIT    = 4'd1;
  localparam logic [3:0] ST_SEED_RD = 4'd2;
  localparam logic [3:0] ST_SEED_WR = 4'd3;
  localparam logic [3:0] ST_POP     = 4'd4;
  localparam logic [3:0] ST_POP_WT  = 4'd5;
  localparam logic [3:0] ST_EMIT    = 4'd6;
  localparam logic [3:0] ST_ROW     = 4'd7;
  localparam logic [3:0] ST_SCAN    = 4'd8;
  localparam logic [3:0] ST_DEC     = 4'd9;
  localparam logic [3:0] ST_FIN     = 4'd10;

  logic [3:0]           state_q, state_d;
  logic [5:0]           node_count_q;
  logic [NCW-1:0]       n;
  logic [1:0]           mode_q, mode_d;
  logic [4:0]           src_q, src_d, dst_q, dst_d;
  logic [NCW-1:0]       i_q, i_d, j_q, j_d;
  logic [NCW-1:0]       head_q, head_d, tail_q, tail_d, count_q, count_d;
  logic [NW-1:0]        x_q, x_d, pend_id_q, pend_id_d;
  logic                 pend_vld_q, pend_vld_d;
  logic [MAX_NODES-1:0] row_q, row_d;
  logic [MAX_NODES-1:0] row_vld_q, row_vld_d, deg_vld_q, deg_vld_d;

  logic                 out_vld_q, out_vld_d, out_nv_q, out_nv_d;
  logic                 out_last_q, out_last_d, out_all_q, out_all_d;
  logic [NW-1:0]        out_id_q, out_id_d;
  logic                 out_free;

  logic [NW-1:0]        src_idx, dst_idx, i_idx, j_idx;
  logic                 edge_ok, row_bit;
  logic [MAX_NODES-1:0] row_eff;

  logic                 adj_we, indeg_we, wdeg_we, q_we;
  logic [NW-1:0]        adj_raddr, adj_waddr, indeg_raddr, indeg_waddr;
  logic [MAX_NODES-1:0] adj_rdata, adj_wdata;
  logic [DW-1:0]        indeg_rdata, wdeg_rdata, deg_in, deg_out;
  logic [NW-1:0]        q_rdata;
  tsk_pkg::deg_op_e     deg_op;
  tsk_pkg::deg_flags_t  deg_flags;

  always_comb begin
    if (7'(node_count_q) >= 7'(MAX_NODES)) begin
      n = NCW'(MAX_NODES);
    end else begin
      n = NCW'(node_count_q);
    end
  end

  assign src_idx  = NW'(src_q);
  assign dst_idx  = NW'(dst_q);
  assign i_idx    = i_q[NW-1:0];
  assign j_idx    = j_q[NW-1:0];
  assign edge_ok  = (7'(src_q) < 7'(n)) && (7'(dst_q) < 7'(n));
  assign row_eff  = row_vld_q[src_idx] ? adj_rdata : '0;
  assign row_bit  = row_eff[dst_idx];
  assign out_free = !out_vld_q || m_axis_tready;

  assign adj_raddr   = (state_q == ST_IDLE) ? NW'(s_axis_tdata[6:2]) : x_q;
  assign indeg_raddr = (state_q == ST_IDLE) ? NW'(s_axis_tdata[11:7]) : i_idx;
  assign adj_waddr   = src_idx;
  assign indeg_waddr = dst_idx;
  assign adj_wdata   = row_eff ^ (MAX_NODES'(1) << dst_idx);

  // shared degree unit input and operation
  always_comb begin
    case (state_q)
      ST_EDIT: begin
        deg_in = deg_vld_q[dst_idx] ? indeg_rdata : '0;
        deg_op = (mode_q == tsk_pkg::MODE_ADD) ? tsk_pkg::DEG_INC : tsk_pkg::DEG_DEC;
      end
      ST_SEED_WR: begin
        deg_in = deg_vld_q[i_idx] ? indeg_rdata : '0;
        deg_op = tsk_pkg::DEG_PASS;
      end
      ST_DEC: begin
        deg_in = wdeg_rdata;
        deg_op = tsk_pkg::DEG_DEC;
      end
      default: begin
        deg_in = wdeg_rdata;
        deg_op = tsk_pkg::DEG_PASS;
      end
    endcase
  end

  tsk_deg_unit #(.Width(DW)) u_deg (
    .op_i   (deg_op),
    .val_i  (deg_in),
    .val_o  (deg_out),
    .flags_o(deg_flags)
  );

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    src_d      = src_q;
    dst_d      = dst_q;
    i_d        = i_q;
    j_d        = j_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    x_d        = x_q;
    pend_id_d  = pend_id_q;
    pend_vld_d = pend_vld_q;
    row_d      = row_q;
    row_vld_d  = row_vld_q;
    deg_vld_d  = deg_vld_q;
    out_vld_d  = out_vld_q;
    out_id_d   = out_id_q;
    out_nv_d   = out_nv_q;
    out_last_d = out_last_q;
    out_all_d  = out_all_q;
    adj_we     = 1'b0;
    indeg_we   = 1'b0;
    wdeg_we    = 1'b0;
    q_we       = 1'b0;

    if (m_axis_tvalid && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d = s_axis_tdata[1:0];
          src_d  = s_axis_tdata[6:2];
          dst_d  = s_axis_tdata[11:7];
          if (s_axis_tdata[1:0] == tsk_pkg::MODE_ADD ||
              s_axis_tdata[1:0] == tsk_pkg::MODE_DEL) begin
            state_d = ST_EDIT;
          end else if (s_axis_tdata[1:0] == tsk_pkg::MODE_SORT) begin
            head_d     = '0;
            tail_d     = '0;
            count_d    = '0;
            i_d        = '0;
            pend_vld_d = 1'b0;
            state_d    = (n == '0) ? ST_FIN : ST_SEED_RD;
          end
        end
      end
      ST_EDIT: begin
        if (edge_ok && ((mode_q == tsk_pkg::MODE_ADD && !row_bit) ||
                        (mode_q == tsk_pkg::MODE_DEL && row_bit))) begin
          adj_we             = 1'b1;
          indeg_we           = 1'b1;
          row_vld_d[src_idx] = 1'b1;
          deg_vld_d[dst_idx] = 1'b1;
        end
        state_d = ST_IDLE;
      end
      ST_SEED_RD: begin
        state_d = ST_SEED_WR;
      end
      ST_SEED_WR: begin
        wdeg_we = 1'b1;
        if (deg_flags.in_zero) begin
          q_we   = 1'b1;
          tail_d = tail_q + NCW'(1);
        end
        i_d     = i_q + NCW'(1);
        state_d = (i_q + NCW'(1) == n) ? ST_POP : ST_SEED_RD;
      end
      ST_POP: begin
        if (head_q < tail_q) begin
          head_d  = head_q + NCW'(1);
          state_d = ST_POP_WT;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_POP_WT: begin
        x_d     = q_rdata;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // previous node goes out only now that it is known not to be the last
        if (out_free) begin
          if (pend_vld_q) begin
            out_vld_d  = 1'b1;
            out_id_d   = pend_id_q;
            out_nv_d   = 1'b1;
            out_last_d = 1'b0;
            out_all_d  = 1'b0;
          end
          pend_id_d  = x_q;
          pend_vld_d = 1'b1;
          count_d    = count_q + NCW'(1);
          state_d    = ST_ROW;
        end
      end
      ST_ROW: begin
        row_d   = row_vld_q[x_q] ? adj_rdata : '0;
        j_d     = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (j_q == n) begin
          state_d = ST_POP;
        end else if (row_q[j_idx]) begin
          state_d = ST_DEC;
        end else begin
          j_d = j_q + NCW'(1);
        end
      end
      ST_DEC: begin
        if (!deg_flags.in_zero) begin
          wdeg_we = 1'b1;
          if (deg_flags.out_zero) begin
            q_we   = 1'b1;
            tail_d = tail_q + NCW'(1);
          end
        end
        j_d     = j_q + NCW'(1);
        state_d = ST_SCAN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_last_d = 1'b1;
          if (pend_vld_q) begin
            out_id_d  = pend_id_q;
            out_nv_d  = 1'b1;
            out_all_d = (count_q == n);
          end else begin
            out_id_d  = '0;
            out_nv_d  = 1'b0;
            out_all_d = (n == '0);
          end
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  tsk_ram #(.Width(MAX_NODES), .Depth(MAX_NODES)) u_adj_ram (
    .clk_i  (clk_i),
    .we_i   (adj_we),
    .waddr_i(adj_waddr),
    .wdata_i(adj_wdata),
    .raddr_i(adj_raddr),
    .rdata_o(adj_rdata)
  );

  tsk_ram #(.Width(DW), .Depth(MAX_NODES)) u_indeg_ram (
    .clk_i  (clk_i),
    .we_i   (indeg_we),
    .waddr_i(indeg_waddr),
    .wdata_i(deg_out),
    .raddr_i(indeg_raddr),
    .rdata_o(indeg_rdata)
  );

  // work degrees: written at i while seeding, at j while relaxing successors
  tsk_ram #(.Width(DW), .Depth(MAX_NODES)) u_wdeg_ram (
    .clk_i  (clk_i),
    .we_i   (wdeg_we),
    .waddr_i((state_q == ST_SEED_WR) ? i_idx : j_idx),
    .wdata_i(deg_out),
    .raddr_i(j_idx),
    .rdata_o(wdeg_rdata)
  );

  tsk_ram #(.Width(NW), .Depth(MAX_NODES)) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (q_we),
    .waddr_i(tail_q[NW-1:0]),
    .wdata_i((state_q == ST_SEED_WR) ? i_idx : j_idx),
    .raddr_i(head_q[NW-1:0]),
    .rdata_o(q_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      node_count_q <= 6'd32;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      i_q          <= '0;
      j_q          <= '0;
      pend_vld_q   <= 1'b0;
      row_vld_q    <= '0;
      deg_vld_q    <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      i_q        <= i_d;
      j_q        <= j_d;
      pend_vld_q <= pend_vld_d;
      row_vld_q  <= row_vld_d;
      deg_vld_q  <= deg_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    src_q      <= src_d;
    dst_q      <= dst_d;
    x_q        <= x_d;
    pend_id_q  <= pend_id_d;
    row_q      <= row_d;
    out_id_q   <= out_id_d;
    out_nv_q   <= out_nv_d;
    out_last_q <= out_last_d;
    out_all_q  <= out_all_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, 5'(out_id_q)};
  assign m_axis_tuser  = {out_all_q, out_nv_q};
  assign m_axis_tlast  = out_last_q;

  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("queue head passed tail");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_vld_q)
    else $error("pending node left over after sort");

  a_dec_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEC) |-> (j_q < n))
    else $error("successor index out of range");

  a_edit_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EDIT) |=> (state_q == ST_IDLE))
    else $error("edit did not finish in one cycle");

endmodule

// ===== sim/tb_topological_sort_kahn.sv =====
`timescale 1ns / 1ps

module tb_topological_sort_kahn;

  localparam int unsigned NODES = 32;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam logic [1:0] MODE_NONE = 2'd3;  // unused code, block drops it

  typedef struct packed {
    logic [4:0] node_id;
    logic       node_valid;
    logic       last;
    logic       all_sorted;
  } order_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [5:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  topological_sort_kahn #(.MAX_NODES(NODES)) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // graph mirror
  logic [NODES-1:0] succ_rows[NODES];
  logic [5:0]       in_deg[NODES];
  logic [5:0]       node_count;

  logic [15:0]  cmd_q[$];
  order_beat_t  topo_order_q[$];
  logic [9:0]   planned_edges[$];  // {src, dst} the stimulus has added

  int unsigned gap_pct, stall_pct, gen_nodes;
  int unsigned cmds_queued, cmds_taken, sorts_taken, beats_checked, cfg_writes;
  int unsigned err_count, cycles;
  order_beat_t got_beat, want_beat;

  function automatic logic [15:0] pack_cmd(logic [1:0] op, logic [4:0] src, logic [4:0] dst);
    return {4'b0, dst, src, op};
  endfunction

  // Applies edits to the mirror; a sort is a Kahn walk, FIFO seeded ascending, successors scanned ascending
  task automatic apply_graph_op(input logic [15:0] cmd);
    logic [1:0]  op;
    logic [4:0]  src, dst, x;
    logic [5:0]  work[NODES];
    logic [4:0]  ready[$];
    logic [4:0]  visit[$];
    order_beat_t b;
    int unsigned n;
    op  = cmd[1:0];
    src = cmd[6:2];
    dst = cmd[11:7];
    n   = (node_count > NODES) ? NODES : node_count;
    case (op)
      tsk_pkg::MODE_ADD: begin
        if (src < n && dst < n && !succ_rows[src][dst]) begin
          succ_rows[src][dst] = 1'b1;
          in_deg[dst] = in_deg[dst] + 6'd1;
        end
      end
      tsk_pkg::MODE_DEL: begin
        if (src < n && dst < n && succ_rows[src][dst]) begin
          succ_rows[src][dst] = 1'b0;
          if (in_deg[dst] != 0) in_deg[dst] = in_deg[dst] - 6'd1;
        end
      end
      tsk_pkg::MODE_SORT: begin
        sorts_taken++;
        for (int i = 0; i < n; i++) begin
          work[i] = in_deg[i];
          if (work[i] == 0) ready.insert(ready.size(), i[4:0]);
        end
        while (ready.size() != 0) begin
          x = ready.pop_front();
          visit.insert(visit.size(), x);
          for (int j = 0; j < n; j++) begin
            if (succ_rows[x][j] && work[j] != 0) begin
              work[j] = work[j] - 6'd1;
              if (work[j] == 0) ready.insert(ready.size(), j[4:0]);
            end
          end
        end
        if (visit.size() == 0) begin
          b = {5'd0, 1'b0, 1'b1, (n == 0)};
          topo_order_q.insert(topo_order_q.size(), b);
        end else begin
          foreach (visit[k]) begin
            b.node_id    = visit[k];
            b.node_valid = 1'b1;
            b.last       = (k == visit.size() - 1);
            b.all_sorted = b.last && (visit.size() == n);
            topo_order_q.insert(topo_order_q.size(), b);
          end
        end
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_graph_op(s_axis_tdata);
        cmds_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cmd_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_beat = {m_axis_tdata[4:0], m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
        if (topo_order_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: unexpected beat id=%0d valid=%0b last=%0b all=%0b", $realtime,
                     got_beat.node_id, got_beat.node_valid, got_beat.last,
                     got_beat.all_sorted);
        end else begin
          want_beat = topo_order_q.pop_front();
          beats_checked++;
          if (got_beat.node_id !== want_beat.node_id ||
              got_beat.node_valid !== want_beat.node_valid ||
              got_beat.last !== want_beat.last ||
              got_beat.all_sorted !== want_beat.all_sorted) begin
            err_count++;
            if (err_count <= 10)
              $display({"%0t: mismatch exp id=%0d valid=%0b last=%0b all=%0b,",
                        " got id=%0d valid=%0b last=%0b all=%0b"},
                       $realtime, want_beat.node_id, want_beat.node_valid, want_beat.last,
                       want_beat.all_sorted, got_beat.node_id, got_beat.node_valid,
                       got_beat.last, got_beat.all_sorted);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic queue_cmd(input logic [1:0] op, input logic [4:0] src, input logic [4:0] dst);
    cmd_q.insert(cmd_q.size(), pack_cmd(op, src, dst));
    cmds_queued++;
  endtask

  task automatic wait_drained();
    while (cmds_taken != cmds_queued || topo_order_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_node_count(input logic [5:0] value);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    node_count = value;
    gen_nodes  = (value > NODES) ? NODES : value;
    cfg_writes++;
  endtask

  // mostly forward edge adds so the graph stays largely acyclic, with deletes and sorts;
  // some back edges, self loops, misses, out-of-range nodes and dead codes as noise
  task automatic queue_random_cmds(input int unsigned count);
    int unsigned r, a, b, k;
    logic [9:0] e;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      a = $urandom_range(gen_nodes - 1);
      b = $urandom_range(gen_nodes - 1);
      if (r < 12) begin
        queue_cmd(tsk_pkg::MODE_SORT, 5'($urandom_range(31)), 5'($urandom_range(31)));
      end else if (r < 15) begin
        queue_cmd(MODE_NONE, 5'($urandom_range(31)), 5'($urandom_range(31)));
      end else if (r < 22 && gen_nodes < NODES) begin
        if ($urandom_range(1)) a = $urandom_range(31, gen_nodes);
        else b = $urandom_range(31, gen_nodes);
        queue_cmd($urandom_range(1) ? tsk_pkg::MODE_DEL : tsk_pkg::MODE_ADD, 5'(a), 5'(b));
      end else if (r < 42) begin
        if (planned_edges.size() != 0 && $urandom_range(99) < 70) begin
          k = $urandom_range(planned_edges.size() - 1);
          e = planned_edges[k];
          planned_edges.delete(k);
          queue_cmd(tsk_pkg::MODE_DEL, e[9:5], e[4:0]);
        end else begin
          queue_cmd(tsk_pkg::MODE_DEL, 5'(a), 5'(b));
        end
      end else begin
        if ($urandom_range(99) < 85 && a != b) begin
          if (a > b) begin
            k = a;
            a = b;
            b = k;
          end
        end
        planned_edges.insert(planned_edges.size(), {a[4:0], b[4:0]});
        queue_cmd(tsk_pkg::MODE_ADD, 5'(a), 5'(b));
      end
    end
  endtask

  initial begin
    int unsigned plan_nc[6], plan_gap[6], plan_stall[6], plan_len[6];
    foreach (succ_rows[i]) begin
      succ_rows[i] = '0;
      in_deg[i]    = '0;
    end
    node_count = 6'd32;
    gen_nodes  = NODES;
    gap_pct    = 0;
    stall_pct  = 0;
    plan_nc    = '{32, 8, 1, 32, $urandom_range(2, 31), 32};
    plan_gap   = '{0, 51, 0, 33, 51, 33};
    plan_stall = '{0, 0, 51, 33, 0, 51};
    plan_len   = '{55, 55, 30, 55, 55, 55};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty graph, duplicates, misses, cycle, self loop, dead code
    write_node_count(6'd32);
    queue_cmd(tsk_pkg::MODE_SORT, 5'd0, 5'd0);
    queue_cmd(tsk_pkg::MODE_ADD, 5'd0, 5'd31);
    queue_cmd(tsk_pkg::MODE_ADD, 5'd0, 5'd31);
    queue_cmd(tsk_pkg::MODE_ADD, 5'd5, 5'd3);
    queue_cmd(tsk_pkg::MODE_DEL, 5'd7, 5'd8);
    queue_cmd(tsk_pkg::MODE_SORT, 5'd31, 5'd31);
    queue_cmd(tsk_pkg::MODE_ADD, 5'd31, 5'd0);
    queue_cmd(tsk_pkg::MODE_SORT, 5'd0, 5'd0);
    queue_cmd(tsk_pkg::MODE_DEL, 5'd31, 5'd0);
    queue_cmd(tsk_pkg::MODE_ADD, 5'd4, 5'd4);
    queue_cmd(tsk_pkg::MODE_SORT, 5'd0, 5'd0);
    queue_cmd(tsk_pkg::MODE_DEL, 5'd4, 5'd4);
    queue_cmd(MODE_NONE, 5'd31, 5'd31);
    queue_cmd(tsk_pkg::MODE_ADD, 5'd20, 5'd2);
    queue_cmd(tsk_pkg::MODE_SORT, 5'd0, 5'd0);
    // shrink: edges from nodes 20 and 5 still hold back nodes 2 and 3
    write_node_count(6'd4);
    queue_cmd(tsk_pkg::MODE_SORT, 5'd0, 5'd0);
    queue_cmd(tsk_pkg::MODE_ADD, 5'd3, 5'd5);
    // single node: self loop gives the empty order
    write_node_count(6'd1);
    queue_cmd(tsk_pkg::MODE_ADD, 5'd0, 5'd0);
    queue_cmd(tsk_pkg::MODE_SORT, 5'd0, 5'd0);
    queue_cmd(tsk_pkg::MODE_DEL, 5'd0, 5'd0);
    queue_cmd(tsk_pkg::MODE_SORT, 5'd0, 5'd0);
    write_node_count(6'd32);
    queue_cmd(tsk_pkg::MODE_DEL, 5'd20, 5'd2);
    queue_cmd(tsk_pkg::MODE_DEL, 5'd0, 5'd31);
    queue_cmd(tsk_pkg::MODE_DEL, 5'd5, 5'd3);
    queue_cmd(tsk_pkg::MODE_SORT, 5'd0, 5'd0);

    for (int p = 0; p < 6; p++) begin
      write_node_count(6'(plan_nc[p]));
      gap_pct   = plan_gap[p];
      stall_pct = plan_stall[p];
      queue_random_cmds(plan_len[p]);
    end
    wait_drained();
    err_count += topo_order_q.size();

    $display("covered %0d commands (%0d sorts), %0d order beats checked, %0d node count writes",
             cmds_taken, sorts_taken, beats_checked, cfg_writes);
    $display("node counts 1 to 32, shrunk graphs, cycles and self loops, idle and stall mixes");
    if (err_count == 0) begin
      $display("tb_topological_sort_kahn: done, clean");
    end else begin
      $display("tb_topological_sort_kahn: done, errors");
    end
    $finish;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("tb_topological_sort_kahn: done, errors");
    $finish;
  end

endmodule
